### hw/rtl/sbs_pkg.sv
// Shared types and constants for the byte string sorter.
// Used by sbs_cell, byte_string_sorter and sbs_checker; no dependencies.
package sbs_pkg;

   localparam int MaxLenDefault = 64;
   localparam int ByteWidth     = 8;

   typedef logic [ByteWidth-1:0] byte_type;

   typedef struct packed {
      logic     valid;
      byte_type data;
   } sbs_entry_type;

   typedef struct packed {
      sbs_entry_type entry;
      logic          gt;
   } sbs_link_type;

   typedef enum logic {
      SBS_LOAD,
      SBS_DRAIN
   } sbs_state_type;

endpackage

### hw/rtl/sbs_cell.sv
// One cell of the insertion chain: holds one sorted byte and its valid bit.
// Depends on sbs_pkg.
module sbs_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  ins_en,
   input  logic                  shift_en,
   input  sbs_pkg::byte_type     ins_byte,
   input  sbs_pkg::sbs_link_type prev_link,
   input  sbs_pkg::sbs_entry_type next_entry,
   output sbs_pkg::sbs_link_type own_link
);

   logic              valid_ff;
   logic              valid_in;
   sbs_pkg::byte_type data_ff;
   sbs_pkg::byte_type data_in;
   logic              gt;

   always_comb begin
      gt       = !valid_ff || (data_ff > ins_byte);
      valid_in = valid_ff;
      data_in  = data_ff;
      priority if (shift_en) begin
         valid_in = next_entry.valid;
         data_in  = next_entry.data;
      end else if (ins_en && gt) begin
         if (prev_link.gt) begin
            valid_in = prev_link.entry.valid;
            data_in  = prev_link.entry.data;
         end else begin
            valid_in = 1'b1;
            data_in  = ins_byte;
         end
      end else begin
         valid_in = valid_ff;
         data_in  = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign own_link.entry.valid = valid_ff;
   assign own_link.entry.data  = data_ff;
   assign own_link.gt          = gt;

endmodule

### hw/rtl/byte_string_sorter.sv
// Top level of the byte string sorter: control and a chain of sbs_cell.
// Depends on sbs_pkg and sbs_cell.
//
//   channel | direction | ports
//   req     | in        | req_valid, req_ready, req_in_byte, req_in_last
//   rsp     | out       | rsp_valid, rsp_ready, rsp_out_byte, rsp_out_last, rsp_overflowed
//
// Loading takes one byte per cycle; each byte is compared in parallel by every
// cell and inserted in place, or dropped if the chain is full. After the marked byte
// the kept bytes leave from the head cell, one per cycle while rsp_ready is high.
// req_ready is low while bytes are being emitted. rsp stalls hold the chain.
// Reset clears all valid bits directly; no clearing pass.
module byte_string_sorter #(
   parameter int MAX_LEN = sbs_pkg::MaxLenDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sbs_pkg::byte_type req_in_byte,
   input  logic              req_in_last,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sbs_pkg::byte_type rsp_out_byte,
   output logic              rsp_out_last,
   output logic              rsp_overflowed
);

   sbs_pkg::sbs_state_type state_ff;
   sbs_pkg::sbs_state_type state_in;
   logic                   overflow_ff;
   logic                   overflow_in;
   logic                   req_take;
   logic                   rsp_take;
   logic                   full;
   logic                   ins_en;
   sbs_pkg::sbs_link_type  links [MAX_LEN];

   assign full      = links[MAX_LEN-1].entry.valid;
   assign req_take  = req_valid && req_ready;
   assign rsp_take  = rsp_valid && rsp_ready;
   assign ins_en    = req_take && !full;

   assign rsp_out_byte   = links[0].entry.data;
   assign rsp_out_last   = !links[1].entry.valid;
   assign rsp_overflowed = overflow_ff;

   always_comb begin
      state_in    = state_ff;
      overflow_in = overflow_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      unique case (state_ff)
         sbs_pkg::SBS_LOAD: begin
            req_ready = 1'b1;
            if (req_take) begin
               if (full) begin
                  overflow_in = 1'b1;
               end
               if (req_in_last) begin
                  state_in = sbs_pkg::SBS_DRAIN;
               end
            end
         end
         sbs_pkg::SBS_DRAIN: begin
            rsp_valid = links[0].entry.valid;
            if (rsp_take && rsp_out_last) begin
               state_in    = sbs_pkg::SBS_LOAD;
               overflow_in = 1'b0;
            end
         end
         default: begin
            state_in = sbs_pkg::SBS_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= sbs_pkg::SBS_LOAD;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         overflow_ff <= overflow_in;
      end
   end

   for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
      sbs_pkg::sbs_link_type  prev_link;
      sbs_pkg::sbs_entry_type next_entry;

      if (i == 0) begin : g_head
         assign prev_link = '0;
      end else begin : g_body
         assign prev_link = links[i-1];
      end

      if (i == MAX_LEN - 1) begin : g_tail
         assign next_entry = '0;
      end else begin : g_mid
         assign next_entry = links[i+1].entry;
      end

      sbs_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ins_en     (ins_en),
         .shift_en   (rsp_take),
         .ins_byte   (req_in_byte),
         .prev_link  (prev_link),
         .next_entry (next_entry),
         .own_link   (links[i])
      );
   end

endmodule

### hw/rtl/sbs_checker.sv
// Port-level checks for byte_string_sorter, bound to the top level.
// Depends on sbs_pkg and byte_string_sorter.
module sbs_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input sbs_pkg::byte_type req_in_byte,
   input logic              req_in_last,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input sbs_pkg::byte_type rsp_out_byte,
   input logic              rsp_out_last,
   input logic              rsp_overflowed
);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("input taken while results pending");

   a_drain_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_in_last) |=> rsp_valid)
      else $error("no result after last input item");

   a_drain_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_out_last) |=> (!rsp_valid && req_ready))
      else $error("results continue after last item");

   a_ovf_steady: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_out_last) |=> (rsp_overflowed == $past(rsp_overflowed)))
      else $error("overflow flag changed within a string");

   a_sorted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_out_last) |=> (rsp_out_byte >= $past(rsp_out_byte)))
      else $error("results out of order");

endmodule

bind byte_string_sorter sbs_checker u_sbs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_in_byte    (req_in_byte),
   .req_in_last    (req_in_last),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_out_last   (rsp_out_last),
   .rsp_overflowed (rsp_overflowed)
);

### sim/tb_byte_string_sorter.sv
// Self-checking testbench for byte_string_sorter: drives byte strings, sorts each
// string in its own model and checks every sorted item the block emits.
// Depends on sbs_pkg and byte_string_sorter.
module tb_byte_string_sorter;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MaxLen    = sbs_pkg::MaxLenDefault;
   localparam int TailWait  = 2 * MaxLen + 20;
   localparam int HoldLen   = 250;
   localparam int IdlePct   = 17;

   typedef struct packed {
      sbs_pkg::byte_type b;
      logic              last;
   } char_item_type;

   typedef struct packed {
      sbs_pkg::byte_type b;
      logic              last;
      logic              ovf;
   } sorted_item_type;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   sbs_pkg::byte_type req_in_byte = '0;
   logic              req_in_last = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   sbs_pkg::byte_type rsp_out_byte;
   logic              rsp_out_last;
   logic              rsp_overflowed;

   char_item_type     pend_q[$];
   sorted_item_type   sorted_q[$];
   sbs_pkg::byte_type kept_bytes[$];
   logic              lost_bytes = 1'b0;
   logic              req_taken = 1'b0;
   int                sent_cnt = 0;
   int                got_cnt = 0;
   int                mismatch_cnt = 0;
   int                hold_left = 0;
   logic              hold_done = 1'b0;

   byte_string_sorter #(.MAX_LEN(MaxLen)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_in_last    (req_in_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_last   (rsp_out_last),
      .rsp_overflowed (rsp_overflowed)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic void sort_in_byte(input sbs_pkg::byte_type b, input logic last);
      int              pos;
      sorted_item_type r;
      if (kept_bytes.size() < MaxLen) begin
         pos = kept_bytes.size();
         while (pos > 0 && kept_bytes[pos-1] > b) pos--;
         kept_bytes.insert(pos, b);
      end else begin
         lost_bytes = 1'b1;
      end
      if (last) begin
         foreach (kept_bytes[i]) begin
            r.b    = kept_bytes[i];
            r.last = (i == kept_bytes.size() - 1);
            r.ovf  = lost_bytes;
            sorted_q.push_back(r);
         end
         kept_bytes.delete();
         lost_bytes = 1'b0;
      end
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_cnt++;
      if (mismatch_cnt <= 10) $display("mismatch: %s", what);
   endtask

   task automatic push_char(input sbs_pkg::byte_type b, input logic last);
      char_item_type c;
      c.b    = b;
      c.last = last;
      pend_q.push_back(c);
   endtask

   task automatic queue_string(input int len, input int lo, input int hi);
      for (int i = 0; i < len; i++)
         push_char(sbs_pkg::byte_type'($urandom_range(hi, lo)), i == len - 1);
   endtask

   // input items feed the sorting model; output items are checked in the same step
   always @(posedge clock) begin
      sorted_item_type want;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         sent_cnt <= sent_cnt + 1;
         sort_in_byte(req_in_byte, req_in_last);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         got_cnt <= got_cnt + 1;
         if (sorted_q.size() == 0) begin
            report_mismatch($sformatf("unexpected item byte=%02h last=%b ovf=%b",
                                      rsp_out_byte, rsp_out_last, rsp_overflowed));
         end else begin
            want = sorted_q.pop_front();
            if (rsp_out_byte !== want.b || rsp_out_last !== want.last ||
                rsp_overflowed !== want.ovf)
               report_mismatch($sformatf(
                  "item %0d expected byte=%02h last=%b ovf=%b got byte=%02h last=%b ovf=%b",
                  got_cnt, want.b, want.last, want.ovf,
                  rsp_out_byte, rsp_out_last, rsp_overflowed));
         end
      end
   end

   always @(negedge clock) begin
      char_item_type nxt;
      logic          go;
      go = 1'b0;
      if (!reset && (!req_valid || req_taken) && pend_q.size() != 0)
         go = (sent_cnt >= 60 && sent_cnt < 120) || ($urandom_range(99) >= IdlePct);
      if (go) begin
         nxt = pend_q.pop_front();
         req_valid   <= 1'b1;
         req_in_byte <= nxt.b;
         req_in_last <= nxt.last;
      end else if (reset || !req_valid || req_taken) begin
         req_valid <= 1'b0;
      end
   end

   // hold off once for a long stretch so the block stalls its output and its input
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && got_cnt >= 30) begin
         rsp_ready <= 1'b0;
         hold_left <= HoldLen;
         hold_done <= 1'b1;
      end else if (got_cnt >= 60 && got_cnt < 140) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= IdlePct);
      end
   end

   initial begin
      int base;
      int mode;
      int len;
      logic full_done;
      logic over_done;

      // single bytes at the extremes, zero byte included
      push_char(8'hFF, 1'b1);
      push_char(8'h00, 1'b1);
      push_char(8'h01, 1'b1);
      // mixed extremes
      push_char(8'h01, 1'b0); push_char(8'hFF, 1'b0); push_char(8'h80, 1'b0);
      push_char(8'h7F, 1'b0); push_char(8'h00, 1'b1);
      // duplicates
      push_char(8'h41, 1'b0); push_char(8'h41, 1'b0); push_char(8'h20, 1'b0);
      push_char(8'h41, 1'b1);
      // descending and ascending runs
      for (int i = 9; i >= 2; i--) push_char(sbs_pkg::byte_type'(i), i == 2);
      push_char(8'h03, 1'b0); push_char(8'h04, 1'b0); push_char(8'h05, 1'b1);

      base      = pend_q.size();
      full_done = 1'b0;
      over_done = 1'b0;
      while (pend_q.size() < 150) begin
         if (!full_done && pend_q.size() >= base + 4) begin
            queue_string(MaxLen, 0, 255);
            full_done = 1'b1;
         end else if (!over_done && full_done) begin
            queue_string(MaxLen + int'($urandom_range(4, 1)), 0, 255);
            over_done = 1'b1;
         end else begin
            mode = $urandom_range(3);
            len  = ($urandom_range(99) < 80) ? $urandom_range(8, 1) : $urandom_range(24, 9);
            case (mode)
               0: queue_string(len, 0, 255);
               1: queue_string(len, 0, 3);
               2: queue_string(len, 252, 255);
               default: queue_string(len, 1, 255);
            endcase
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pend_q.size() != 0 || req_valid || sorted_q.size() != 0) @(posedge clock);
      repeat (TailWait) @(posedge clock);
      if (mismatch_cnt == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #500_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
